### rtl/lpd_pkg.sv
`timescale 1ns / 1ps
package lpd_pkg;

   // packet layout
   localparam int PACKET_BYTES   = 22;
   localparam int WORD_BYTES     = 20;
   localparam int READINGS       = 4;
   localparam int ANGLE_COUNT    = 360;
   localparam int ANGLE_STEPS    = ANGLE_COUNT / READINGS;
   localparam int POS_W          = 5;
   localparam int ACC_W          = 26;
   localparam int FOLD_W         = 15;
   localparam int BASE_W         = 7;
   localparam int READ_W         = 2;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0]       START_BYTE  = 8'hFA;
   localparam logic [7:0]       INDEX_BASE  = 8'hA0;
   localparam logic [POS_W-1:0] POS_INDEX   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CKS_LO  = POS_W'(WORD_BYTES);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(PACKET_BYTES - 1);
   localparam logic [POS_W-1:0] POS_RD_LO   = POS_W'(4);
   localparam logic [POS_W-1:0] POS_RD_HI   = POS_W'(WORD_BYTES - 1);
   localparam int               INVALID_BIT = 7;
   localparam int               HIGH_BITS   = 6;
   localparam logic [READ_W-1:0] LAST_READING = READ_W'(READINGS - 1);

   // one decoded packet, handed from front to back
   typedef struct packed {
      logic [BASE_W-1:0]            base;
      logic [READINGS-1:0][7:0]     lo;
      logic [READINGS-1:0][7:0]     hi;
      logic                         ok;
   } pkt_type;

   typedef struct packed {
      logic push;
      logic full;
   } q_ctl_type;

endpackage

### rtl/lpd_if.sv
`timescale 1ns / 1ps
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  angle;
   logic [13:0] distance;
   logic        invalid;
   logic        checksum_ok;
   logic        last;

   modport source (output valid, output angle, output distance, output invalid,
                   output checksum_ok, output last, input ready);
   modport sink   (input valid, input angle, input distance, input invalid,
                   input checksum_ok, input last, output ready);
endinterface

### rtl/lpd_front.sv
`timescale 1ns / 1ps
module lpd_front
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] rx_byte,
   input  logic       q_full,
   output q_ctl_type  q_ctl,
   output pkt_type    q_data
);

   logic                  in_packet_ff, in_packet_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [7:0]            hold_ff, hold_in;
   logic [BASE_W-1:0]     base_ff;
   logic [READINGS-1:0][7:0] lo_ff, hi_ff;
   logic [7:0]            cks_lo_ff;

   logic                  accept;
   logic                  at_last;
   logic [7:0]            diff;
   logic [BASE_W-1:0]     base_in;
   logic [READ_W-1:0]     rd_idx;
   logic                  rd_slot;
   logic [FOLD_W:0]       fold_sum;
   logic                  ok;

   assign at_last  = in_packet_ff && (pos_ff == POS_LAST);
   assign in_ready = !(at_last && q_full);
   assign accept   = in_valid && in_ready;

   // (index - 0xA0) mod 256 mod 90 by two compare-and-subtract steps
   assign diff = rx_byte - INDEX_BASE;
   always_comb begin
      if (diff >= 8'(2 * ANGLE_STEPS)) begin
         base_in = BASE_W'(diff - 8'(2 * ANGLE_STEPS));
      end else if (diff >= 8'(ANGLE_STEPS)) begin
         base_in = BASE_W'(diff - 8'(ANGLE_STEPS));
      end else begin
         base_in = BASE_W'(diff);
      end
   end

   assign rd_idx  = READ_W'(pos_ff[POS_W-1:2] - 3'd1);
   assign rd_slot = in_packet_ff && (pos_ff >= POS_RD_LO) && (pos_ff <= POS_RD_HI)
                    && !pos_ff[1];

   assign fold_sum = {1'b0, acc_ff[FOLD_W-1:0]} + (FOLD_W+1)'(acc_ff[ACC_W-1:FOLD_W]);
   assign ok       = {1'b0, fold_sum[FOLD_W-1:0]} == {rx_byte, cks_lo_ff};

   always_comb begin
      in_packet_in = in_packet_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      hold_in      = hold_ff;
      if (accept) begin
         if (!in_packet_ff) begin
            if (rx_byte == START_BYTE) begin
               in_packet_in = 1'b1;
               pos_in       = POS_W'(1);
               acc_in       = '0;
               hold_in      = rx_byte;
            end
         end else if (pos_ff == POS_LAST) begin
            in_packet_in = 1'b0;
            pos_in       = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff < POS_CKS_LO) begin
               if (!pos_ff[0]) begin
                  hold_in = rx_byte;
               end else begin
                  acc_in = ACC_W'({acc_ff[ACC_W-2:0], 1'b0} + {10'd0, rx_byte, hold_ff});
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         pos_ff       <= '0;
         acc_ff       <= '0;
         hold_ff      <= '0;
      end else begin
         in_packet_ff <= in_packet_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         hold_ff      <= hold_in;
      end
   end

   // packet payload, written only at its own byte position
   always_ff @(posedge clock) begin
      if (accept && in_packet_ff) begin
         if (pos_ff == POS_INDEX) begin
            base_ff <= base_in;
         end
         if (pos_ff == POS_CKS_LO) begin
            cks_lo_ff <= rx_byte;
         end
         if (rd_slot) begin
            if (pos_ff[0]) begin
               hi_ff[rd_idx] <= rx_byte;
            end else begin
               lo_ff[rd_idx] <= rx_byte;
            end
         end
      end
   end

   assign q_ctl.push  = accept && at_last;
   assign q_ctl.full  = q_full;
   assign q_data.base = base_ff;
   assign q_data.lo   = lo_ff;
   assign q_data.hi   = hi_ff;
   assign q_data.ok   = ok;

   a_hunt_pos: assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> pos_ff == '0)
      else $error("byte position not cleared while hunting");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> (pos_ff != '0) && (pos_ff <= POS_LAST))
      else $error("byte position out of packet");

endmodule

### rtl/lpd_queue.sv
`timescale 1ns / 1ps
module lpd_queue
   import lpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  q_ctl_type wr_ctl,
   input  pkt_type   wr_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output pkt_type   head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pkt_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, take;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign push       = wr_ctl.push && !full;
   assign take       = pop && head_valid;
   assign head       = mem[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (take) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !take) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (take && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

### rtl/lpd_back.sv
`timescale 1ns / 1ps
module lpd_back
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  pkt_type     head,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [8:0]  angle,
   output logic [13:0] distance,
   output logic        invalid,
   output logic        checksum_ok,
   output logic        last
);

   logic [READ_W-1:0] reading_ff;
   logic              valid_ff;
   logic [8:0]        angle_ff;
   logic [13:0]       distance_ff;
   logic              invalid_ff, ok_ff, last_ff;

   logic              load, take, bad;
   logic [7:0]        hi, lo;

   assign load = !valid_ff || out_ready;
   assign take = load && head_valid;
   assign pop  = take && (reading_ff == LAST_READING);

   assign hi  = head.hi[reading_ff];
   assign lo  = head.lo[reading_ff];
   assign bad = hi[INVALID_BIT] || !head.ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            reading_ff <= reading_ff + READ_W'(1);
         end
         if (load) begin
            valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         angle_ff    <= {head.base, reading_ff};
         distance_ff <= bad ? '0 : {hi[HIGH_BITS-1:0], lo};
         invalid_ff  <= bad;
         ok_ff       <= head.ok;
         last_ff     <= reading_ff == LAST_READING;
      end
   end

   assign out_valid   = valid_ff;
   assign angle       = angle_ff;
   assign distance    = distance_ff;
   assign invalid     = invalid_ff;
   assign checksum_ok = ok_ff;
   assign last        = last_ff;

   a_burst: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |=> valid_ff)
      else $error("packet results broken off before the last reading");

   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && invalid_ff |-> distance_ff == '0)
      else $error("invalid reading carries a distance");

endmodule

### rtl/lidar_packet_decoder_unit.sv
`timescale 1ns / 1ps
// Rangefinder packet decoder: takes the sensor's serial stream one byte per transfer on req_chan,
// hunts for the 0xFA start byte and collects a 22-byte packet (start, index, two speed bytes,
// four 4-byte readings, little-endian checksum). Each packet gives four transfers on rsp_chan,
// one per reading: angle ((index-0xA0) mod 90)*4 + reading, 14-bit distance (zero when
// invalid), invalid (bit 7 of the high byte set or checksum bad), checksum_ok and last on the
// fourth. Bytes are taken one per clock; the only stall on req_chan is at a packet's final byte
// when the packet queue (QUEUE_DEPTH entries) is full. Results leave the back end at one per
// clock while rsp_chan is ready: a packet's first result passes through the packet queue, then
// the output register, and its other three results follow in order. No resync mid-packet:
// 0xFA inside a packet is ordinary data.
module lidar_packet_decoder_unit
   import lpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lpd_req_if.sink   req_chan,
   lpd_rsp_if.source rsp_chan
);

   // front to queue
   q_ctl_type q_ctl;
   pkt_type   q_wr_data;
   logic      q_full;

   // queue to back
   logic      q_head_valid;
   pkt_type   q_head;
   logic      q_pop;

   // front: hunts, tracks byte position, builds the checksum and the packet record
   lpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .rx_byte  (req_chan.rx_byte),
      .q_full   (q_full),
      .q_ctl    (q_ctl),
      .q_data   (q_wr_data)
   );

   // short packet queue decoupling byte intake from result delivery
   lpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_ctl     (q_ctl),
      .wr_data    (q_wr_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // back: steps through the four readings into a registered result stage
   lpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head        (q_head),
      .pop         (q_pop),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .angle       (rsp_chan.angle),
      .distance    (rsp_chan.distance),
      .invalid     (rsp_chan.invalid),
      .checksum_ok (rsp_chan.checksum_ok),
      .last        (rsp_chan.last)
   );

endmodule

### bench/lidar_packet_decoder_unit_tb.sv
`timescale 1ns / 1ps
module lidar_packet_decoder_unit_tb;
   import lpd_pkg::*;

   // run bounds
   localparam int QUIET_LIMIT    = 1000;  // cycles with no transfer on either channel
   localparam int DRAIN_CYCLES   = 20;    // settle time once every reading has arrived
   localparam int DIRECTED_ROWS  = 8;
   localparam int ITEM_TARGET    = 200;   // input bytes to reach before the random part stops
   localparam int REPORT_LIMIT   = 10;

   // filler sent while the decoder is hunting, never the start byte
   localparam logic [3:0][7:0] JUNK_BYTES = {8'hF9, 8'hFB, 8'hFF, 8'h00};

   // how the checksum field of a built packet is filled
   typedef enum logic [1:0] {
      CKS_GOOD,     // matches the folded sum
      CKS_FLIPPED,  // good value with bit 0 inverted
      CKS_TOP_BIT,  // good value with bit 15 set, so it can never match
      CKS_RANDOM
   } cks_mode_type;

   // one decoded reading as it leaves on rsp_chan
   typedef struct packed {
      logic [8:0]  angle;
      logic [13:0] distance;
      logic        invalid;
      logic        checksum_ok;
      logic        last;
   } reading_type;

   // one row of the directed table; per-reading fields run reading 3 down to reading 0
   typedef struct packed {
      logic [1:0]       noise;   // junk bytes ahead of the start byte
      logic [7:0]       index;
      logic [15:0]      speed;
      logic [3:0][7:0]  lo;
      logic [3:0][7:0]  hi;
      cks_mode_type     cks;
      logic             typed;   // readings below are typed in, else predicted
      logic [8:0]       angle0;
      logic [3:0][13:0] want_dist;
      logic [3:0]       bad;
      logic             ok;
   } frame_row_type;

   logic clock;
   logic reset;

   lpd_req_if req_chan ();
   lpd_rsp_if rsp_chan ();

   lidar_packet_decoder_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // decoder shadow state
   logic                collecting;
   logic [POS_W-1:0]    next_pos;
   logic [7:0]          frame_seen [PACKET_BYTES];
   logic [ACC_W-1:0]    sum_acc;
   logic [7:0]          low_hold;

   // readings still owed by the decoder, oldest first
   reading_type         pending_readings [$];
   reading_type         typed_readings [READINGS];
   bit                  typed_armed;

   // packet under construction on the sending side
   logic [7:0]          tx_frame [PACKET_BYTES];
   frame_row_type       directed_rows [DIRECTED_ROWS];

   int unsigned         max_gap;
   int unsigned         max_stall;
   int unsigned         sent_bytes;
   int unsigned         fail_count;
   int unsigned         quiet_cycles;

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the decoder: consumes one accepted byte, queues the readings it completes
   function automatic void decode_byte(input logic [7:0] b);
      reading_type   r;
      logic [14:0]   folded;
      logic [15:0]   received;
      logic [7:0]    offset;
      logic [6:0]    base;
      logic          ok;
      logic [7:0]    lo;
      logic [7:0]    hi;
      if (!collecting) begin
         // hunting: anything but the start byte is dropped
         if (b != START_BYTE)
            return;
         collecting = 1'b1;
         next_pos   = '0;
         sum_acc    = '0;
         low_hold   = '0;
      end
      frame_seen[next_pos] = b;
      // ten little-endian words, shift left by one and add
      if (next_pos < WORD_BYTES) begin
         if (!next_pos[0])
            low_hold = b;
         else
            sum_acc = (sum_acc << 1) + ACC_W'({b, low_hold});
      end
      if (next_pos != POS_LAST) begin
         next_pos = next_pos + POS_W'(1);
         return;
      end
      collecting = 1'b0;
      next_pos   = '0;
      // fold to 15 bits; received value is compared whole, bit 15 included
      folded   = sum_acc[FOLD_W-1:0] + FOLD_W'(sum_acc[ACC_W-1:FOLD_W]);
      received = {frame_seen[PACKET_BYTES-1], frame_seen[PACKET_BYTES-2]};
      ok       = ({1'b0, folded} == received);
      offset   = frame_seen[1] - INDEX_BASE;  // wraps at 8 bits before the modulo
      base     = 7'(offset % ANGLE_STEPS);
      for (int k = 0; k < READINGS; k++) begin
         lo              = frame_seen[4 + 4 * k];
         hi              = frame_seen[5 + 4 * k];
         r.angle         = {base, 2'(k)};
         r.invalid       = hi[INVALID_BIT] || !ok;   // strength warning bit is ignored
         r.distance      = r.invalid ? 14'd0 : {hi[HIGH_BITS-1:0], lo};
         r.checksum_ok   = ok;
         r.last          = (k == READINGS - 1);
         pending_readings.push_back(typed_armed ? typed_readings[k] : r);
      end
      typed_armed = 1'b0;
   endfunction

   // lay out a whole packet in tx_frame, checksum last
   task automatic build_frame(input logic [7:0] index, input logic [15:0] speed,
                              input logic [3:0][7:0] lo, input logic [3:0][7:0] hi,
                              input cks_mode_type cks);
      logic [ACC_W-1:0] acc;
      logic [14:0]      folded;
      logic [15:0]      cks_value;
      tx_frame[0] = START_BYTE;
      tx_frame[1] = index;
      tx_frame[2] = speed[7:0];
      tx_frame[3] = speed[15:8];
      for (int k = 0; k < READINGS; k++) begin
         tx_frame[4 + 4 * k] = lo[k];
         tx_frame[5 + 4 * k] = hi[k];
         tx_frame[6 + 4 * k] = 8'($urandom);   // strength bytes, never looked at
         tx_frame[7 + 4 * k] = 8'($urandom);
      end
      acc = '0;
      for (int w = 0; w < WORD_BYTES / 2; w++)
         acc = (acc << 1) + ACC_W'({tx_frame[2 * w + 1], tx_frame[2 * w]});
      folded    = acc[FOLD_W-1:0] + FOLD_W'(acc[ACC_W-1:FOLD_W]);
      cks_value = {1'b0, folded};
      case (cks)
         CKS_FLIPPED: cks_value = cks_value ^ 16'h0001;
         CKS_TOP_BIT: cks_value = cks_value | 16'h8000;
         CKS_RANDOM:  cks_value = 16'($urandom);
         default:     ;
      endcase
      tx_frame[PACKET_BYTES-2] = cks_value[7:0];
      tx_frame[PACKET_BYTES-1] = cks_value[15:8];
   endtask

   // one byte transfer on req_chan, after a random gap; returns at the falling edge
   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent_bytes++;
      decode_byte(b);
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned len);
      for (int i = 0; i < len; i++)
         push_byte(tx_frame[i]);
   endtask

   // result side: random stall before each transfer, none at all when max_stall is 0
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         stall = $urandom_range(0, max_stall);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // compare every result transfer with the oldest owed reading
   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_readings.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected reading: angle %0d distance %0d invalid %b ok %b last %b",
                        rsp_chan.angle, rsp_chan.distance, rsp_chan.invalid,
                        rsp_chan.checksum_ok, rsp_chan.last);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_chan.angle !== want.angle || rsp_chan.distance !== want.distance ||
                rsp_chan.invalid !== want.invalid ||
                rsp_chan.checksum_ok !== want.checksum_ok || rsp_chan.last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"reading mismatch at %0t: expected angle %0d distance %0d ",
                            "invalid %b ok %b last %b, got angle %0d distance %0d ",
                            "invalid %b ok %b last %b"}, $realtime,
                           want.angle, want.distance, want.invalid, want.checksum_ok,
                           want.last, rsp_chan.angle, rsp_chan.distance, rsp_chan.invalid,
                           rsp_chan.checksum_ok, rsp_chan.last);
            end
         end
      end
   end

   // watchdog: too long with no transfer on either side means the decoder has hung
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lidar_packet_decoder_unit verification failed");
         $finish;
      end
   end

   initial begin
      frame_row_type row;
      logic [7:0]    index;
      cks_mode_type  cks;
      int unsigned   len;
      int unsigned   pick;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      collecting       = 1'b0;
      next_pos         = '0;
      sum_acc          = '0;
      low_hold         = '0;
      typed_armed      = 1'b0;
      max_gap          = 8;
      max_stall        = 8;
      sent_bytes       = 0;
      fail_count       = 0;
      quiet_cycles     = 0;

      // noise, index, speed, lo r3..r0, hi r3..r0, checksum, typed, angle0,
      // distance r3..r0, bad r3..r0, ok
      // first packet after reset, everything zero
      directed_rows[0] = {2'd3, 8'hA0, 16'h0000, 32'h00000000, 32'h00000000, CKS_GOOD,
                          1'b1, 9'd0, {4{14'd0}}, 4'b0000, 1'b1};
      // largest distance, last angle step, back to back with the previous packet
      directed_rows[1] = {2'd0, 8'hF9, 16'hFFFF, 32'hFFFFFFFF, 32'h3F3F3F3F, CKS_GOOD,
                          1'b1, 9'd356, {4{14'h3FFF}}, 4'b0000, 1'b1};
      // strength warning bit set, readings stay valid
      directed_rows[2] = {2'd1, 8'hA0, 16'h0012, 32'h01020304, 32'h40404040, CKS_GOOD,
                          1'b1, 9'd0, {14'd1, 14'd2, 14'd3, 14'd4}, 4'b0000, 1'b1};
      // invalid bit on three readings; index below the base wraps to 300
      directed_rows[3] = {2'd0, 8'h9F, 16'h0034, 32'h11223344, 32'h00FFBF80, CKS_GOOD,
                          1'b1, 9'd300, {14'd17, 14'd0, 14'd0, 14'd0}, 4'b0111, 1'b1};
      // checksum off by one bit
      directed_rows[4] = {2'd2, 8'h00, 16'h1234, 32'h55AA55AA, 32'h15152A2A, CKS_FLIPPED,
                          1'b1, 9'd24, {4{14'd0}}, 4'b1111, 1'b0};
      // received checksum with bit 15 set never matches
      directed_rows[5] = {2'd0, 8'hFF, 16'hFFFF, 32'h10203040, 32'h01020304, CKS_TOP_BIT,
                          1'b1, 9'd20, {4{14'd0}}, 4'b1111, 1'b0};
      // start byte all over the body is plain data
      directed_rows[6] = {2'd0, 8'hFA, 16'hFAFA, 32'hFAFAFAFA, 32'h3AFA7AFA, CKS_GOOD,
                          1'b0, 9'd0, {4{14'd0}}, 4'b0000, 1'b0};
      directed_rows[7] = {2'd1, 8'hC3, 16'h5AA5, 32'h0F1E2D3C, 32'h00112233, CKS_RANDOM,
                          1'b0, 9'd0, {4{14'd0}}, 4'b0000, 1'b0};

      // reset held from time zero, released on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_rows[n];
         for (int j = 0; j < row.noise; j++)
            push_byte(JUNK_BYTES[(n + j) % 4]);
         build_frame(row.index, row.speed, row.lo, row.hi, row.cks);
         if (row.typed) begin
            for (int k = 0; k < READINGS; k++) begin
               typed_readings[k].angle       = row.angle0 + 9'(k);
               typed_readings[k].distance    = row.want_dist[k];
               typed_readings[k].invalid     = row.bad[k];
               typed_readings[k].checksum_ok = row.ok;
               typed_readings[k].last        = (k == READINGS - 1);
            end
            typed_armed = 1'b1;
         end
         send_frame(PACKET_BYTES);
      end

      // random part: mostly whole packets with random content, some noise and cut-off
      // packets; gaps and stalls switch between busy and back-to-back stretches
      while (sent_bytes < ITEM_TARGET) begin
         max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 8;
         max_stall = ($urandom_range(0, 3) == 0) ? 0 : 8;
         repeat ($urandom_range(0, 3))
            push_byte(8'($urandom));
         index = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hA0, 8'hF9))
                                             : 8'($urandom);
         pick = $urandom_range(0, 9);
         cks  = (pick < 6) ? CKS_GOOD : (pick < 8) ? CKS_FLIPPED
              : (pick < 9) ? CKS_TOP_BIT : CKS_RANDOM;
         build_frame(index, 16'($urandom), $urandom, $urandom, cks);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, PACKET_BYTES - 1)
                                           : PACKET_BYTES;
         send_frame(len);
      end
      req_chan.valid <= 1'b0;

      // let every owed reading come out, then make sure nothing extra follows
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_readings.size() == 0)
         $display("lidar_packet_decoder_unit verification clean");
      else
         $display("lidar_packet_decoder_unit verification failed");
      $finish;
   end

endmodule
